[hdl/eidm_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// eidm_pkg
// Operation and status codes shared by the entity id allocator.
// ============================================================================
package eidm_pkg;

    // Operation codes carried on the kind field.
    localparam logic [2:0] KIND_CREATE = 3'd0;
    localparam logic [2:0] KIND_REMOVE = 3'd1;
    localparam logic [2:0] KIND_SET    = 3'd2;
    localparam logic [2:0] KIND_QUERY  = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;

    // Status codes returned with every result.
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_FULL     = 3'd1;
    localparam logic [2:0] STATUS_BAD_ID   = 3'd2;
    localparam logic [2:0] STATUS_NOT_LIVE = 3'd3;
    localparam logic [2:0] STATUS_RANGE    = 3'd4;

    // Fixed widths of the payload ports.
    localparam int ENTITY_OUT_W = 10;
    localparam int MASK_PORT_W  = 32;
    localparam int TOTAL_W      = 11;

endpackage

[hdl/eidm_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// eidm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module eidm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/entity_id_allocator_mask_table_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// entity_id_allocator_mask_table_top
// Entity id allocator with a FIFO free list, per-id component masks and an
// ordered list of live ids.
// ============================================================================
// Usage:
// A command transaction on the s_ channel (s_valid/s_ready) carries the
// operation in s_kind: create, remove, set component, query mask or read
// list. Every command produces exactly one result transaction on the m_
// channel (m_valid/m_ready) with a status code and the live count after it.
// Commands are processed one at a time. Create, set, query and read load the
// result register after a registered read of the free list, the mask table
// or the live list. Commands refused at acceptance (table full, invalid id,
// index out of range) and undefined kinds go straight to the finish state.
// Remove reads the mask table, then walks the live list through its RAM read
// port, one entry per cycle. In the finish state the result moves into the
// output register once that register is free, and s_ready returns with it.
// The walk and the registered reads of the three state RAMs set how long a command takes.
// The result sits in an output register, so the next command is accepted
// while a result still waits; a stalled receiver blocks only the finish of
// that next command.
// Reset clears all control state at once. RAM contents are not cleared:
// free-list positions not yet written read as their own index, and mask
// entries of ids never handed out read as zero, both decided by the wrap
// state of the free-list pointers. No clearing pass is needed.
// ============================================================================
module entity_id_allocator_mask_table_top #(
    parameter int ENTITY_COUNT   = 1024,
    parameter int COMPONENT_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [15:0] s_entity_id,
    input  logic [4:0]  s_component_id,
    input  logic [31:0] s_mask_in,
    input  logic [9:0]  s_list_index,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [9:0]  m_entity_out,
    output logic [31:0] m_mask_out,
    output logic        m_has_all,
    output logic        m_has_bit,
    output logic [10:0] m_live_total
);

    localparam int ID_W  = $clog2(ENTITY_COUNT);
    localparam int CNT_W = $clog2(ENTITY_COUNT + 1);
    localparam int CB    = COMPONENT_BITS;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_FREE_RD = 6'b000010,
        ST_MASK_RD = 6'b000100,
        ST_LIST_RD = 6'b001000,
        ST_WALK    = 6'b010000,
        ST_FINISH  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Latched command.
    logic [2:0]      kind_reg, kind_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [4:0]      comp_reg, comp_next;
    logic [CB-1:0]   req_reg, req_next;

    // Result being built.
    logic [2:0]  res_status_reg, res_status_next;
    logic [9:0]  res_ent_reg, res_ent_next;
    logic [31:0] res_mask_reg, res_mask_next;
    logic        res_all_reg, res_all_next;
    logic        res_bit_reg, res_bit_next;

    // Free-list pointers and live count.
    logic [ID_W-1:0]  head_reg, head_next;
    logic [ID_W-1:0]  tail_reg, tail_next;
    logic             head_wrap_reg, head_wrap_next;
    logic             tail_wrap_reg, tail_wrap_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Live-list compaction walk.
    logic [CNT_W-1:0] walk_i_reg, walk_i_next;
    logic [CNT_W-1:0] walk_j_reg, walk_j_next;
    logic             walk_rv_reg, walk_rv_next;
    logic             walk_issue;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [2:0]  m_status_reg;
    logic [9:0]  m_entity_out_reg;
    logic [31:0] m_mask_out_reg;
    logic        m_has_all_reg;
    logic        m_has_bit_reg;
    logic [10:0] m_live_total_reg;
    logic        out_load;

    // RAM ports.
    logic            free_we, free_re;
    logic [ID_W-1:0] free_waddr, free_wdata, free_rdata;
    logic            mask_we, mask_re;
    logic [ID_W-1:0] mask_waddr, mask_raddr;
    logic [CB:0]     mask_wdata, mask_rdata;
    logic            list_we, list_re;
    logic [ID_W-1:0] list_waddr, list_raddr, list_wdata, list_rdata;

    // Decode helpers.
    logic            accept;
    logic            id_ok, table_full, index_ok;
    logic [ID_W-1:0] new_id;
    logic            entry_written;
    logic [CB:0]     entry;
    logic            entry_live;
    logic [CB-1:0]   entry_mask;
    logic [63:0]     entry_mask_wide;
    logic [63:0]     comp_onehot;
    logic [63:0]     mask_in_wide;

    eidm_ram #(.WIDTH(ID_W), .DEPTH(ENTITY_COUNT)) u_free_ram (
        .aclk  (aclk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .re    (free_re),
        .raddr (head_reg),
        .rdata (free_rdata)
    );

    eidm_ram #(.WIDTH(CB + 1), .DEPTH(ENTITY_COUNT)) u_mask_ram (
        .aclk  (aclk),
        .we    (mask_we),
        .waddr (mask_waddr),
        .wdata (mask_wdata),
        .re    (mask_re),
        .raddr (mask_raddr),
        .rdata (mask_rdata)
    );

    eidm_ram #(.WIDTH(ID_W), .DEPTH(ENTITY_COUNT)) u_list_ram (
        .aclk  (aclk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (list_wdata),
        .re    (list_re),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign id_ok      = 32'(s_entity_id) < 32'(ENTITY_COUNT);
    assign table_full = (count_reg == CNT_W'(ENTITY_COUNT));
    assign index_ok   = 32'(s_list_index) < 32'(count_reg);
    assign mask_in_wide = 64'(s_mask_in);

    // A free-list slot holds its own index until the tail first writes it.
    assign new_id = (tail_wrap_reg || (head_reg < tail_reg)) ? free_rdata : head_reg;

    // Ids are handed out for the first time in ascending order, so every id
    // below the head (or any id once the head has wrapped) has a written
    // mask entry. Others are read as zero, since the RAM is not cleared.
    assign entry_written   = head_wrap_reg || (id_reg < head_reg);
    assign entry           = entry_written ? mask_rdata : '0;
    assign entry_live      = entry[CB];
    assign entry_mask      = entry[CB-1:0];
    assign entry_mask_wide = 64'(entry_mask);
    assign comp_onehot     = 64'(1) << comp_reg;

    assign walk_issue = (walk_i_reg < count_reg);
    assign out_load   = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        comp_next       = comp_reg;
        req_next        = req_reg;
        res_status_next = res_status_reg;
        res_ent_next    = res_ent_reg;
        res_mask_next   = res_mask_reg;
        res_all_next    = res_all_reg;
        res_bit_next    = res_bit_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        head_wrap_next  = head_wrap_reg;
        tail_wrap_next  = tail_wrap_reg;
        count_next      = count_reg;
        walk_i_next     = walk_i_reg;
        walk_j_next     = walk_j_reg;
        walk_rv_next    = 1'b0;

        free_we    = 1'b0;
        free_re    = 1'b0;
        free_waddr = tail_reg;
        free_wdata = id_reg;
        mask_we    = 1'b0;
        mask_re    = 1'b0;
        mask_waddr = id_reg;
        mask_wdata = '0;
        mask_raddr = ID_W'(s_entity_id);
        list_we    = 1'b0;
        list_re    = 1'b0;
        list_waddr = count_reg[ID_W-1:0];
        list_wdata = new_id;
        list_raddr = ID_W'(s_list_index);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next       = s_kind;
                    id_next         = ID_W'(s_entity_id);
                    comp_next       = s_component_id;
                    req_next        = mask_in_wide[CB-1:0];
                    res_status_next = eidm_pkg::STATUS_OK;
                    res_ent_next    = '0;
                    res_mask_next   = '0;
                    res_all_next    = 1'b0;
                    res_bit_next    = 1'b0;
                    state_next      = ST_FINISH;
                    case (s_kind)
                        eidm_pkg::KIND_CREATE: begin
                            if (table_full) begin
                                res_status_next = eidm_pkg::STATUS_FULL;
                            end else begin
                                free_re    = 1'b1;
                                state_next = ST_FREE_RD;
                            end
                        end
                        eidm_pkg::KIND_REMOVE,
                        eidm_pkg::KIND_SET,
                        eidm_pkg::KIND_QUERY: begin
                            if (!id_ok) begin
                                res_status_next = eidm_pkg::STATUS_BAD_ID;
                            end else begin
                                mask_re    = 1'b1;
                                state_next = ST_MASK_RD;
                            end
                        end
                        eidm_pkg::KIND_READ: begin
                            if (!index_ok) begin
                                res_status_next = eidm_pkg::STATUS_RANGE;
                            end else begin
                                list_re    = 1'b1;
                                state_next = ST_LIST_RD;
                            end
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_FREE_RD: begin
                mask_we    = 1'b1;
                mask_waddr = new_id;
                mask_wdata = {1'b1, req_reg};
                list_we    = 1'b1;
                if (head_reg == ID_W'(ENTITY_COUNT - 1)) begin
                    head_next      = '0;
                    head_wrap_next = 1'b1;
                end else begin
                    head_next = ID_W'(head_reg + 1'b1);
                end
                count_next   = CNT_W'(count_reg + 1'b1);
                res_ent_next = 10'(new_id);
                state_next   = ST_FINISH;
            end

            ST_MASK_RD: begin
                state_next = ST_FINISH;
                case (kind_reg)
                    eidm_pkg::KIND_REMOVE: begin
                        if (!entry_live) begin
                            res_status_next = eidm_pkg::STATUS_NOT_LIVE;
                        end else begin
                            mask_we = 1'b1;
                            free_we = 1'b1;
                            if (tail_reg == ID_W'(ENTITY_COUNT - 1)) begin
                                tail_next      = '0;
                                tail_wrap_next = 1'b1;
                            end else begin
                                tail_next = ID_W'(tail_reg + 1'b1);
                            end
                            walk_i_next = '0;
                            walk_j_next = '0;
                            state_next  = ST_WALK;
                        end
                    end
                    eidm_pkg::KIND_SET: begin
                        if (!entry_live) begin
                            res_status_next = eidm_pkg::STATUS_NOT_LIVE;
                        end else begin
                            mask_we    = 1'b1;
                            mask_wdata = {1'b1, entry_mask | comp_onehot[CB-1:0]};
                        end
                    end
                    default: begin
                        if (!entry_live) begin
                            res_status_next = eidm_pkg::STATUS_NOT_LIVE;
                        end
                        res_mask_next = entry_mask_wide[31:0];
                        res_all_next  = ((req_reg & ~entry_mask) == '0);
                        res_bit_next  = entry_mask_wide[{1'b0, comp_reg}];
                    end
                endcase
            end

            ST_LIST_RD: begin
                res_ent_next = 10'(list_rdata);
                state_next   = ST_FINISH;
            end

            ST_WALK: begin
                // Read one entry per cycle; each entry that is not the removed
                // id is written back at the compacted position in the following cycle.
                list_raddr = walk_i_reg[ID_W-1:0];
                if (walk_issue) begin
                    list_re      = 1'b1;
                    walk_i_next  = CNT_W'(walk_i_reg + 1'b1);
                    walk_rv_next = 1'b1;
                end
                if (walk_rv_reg && (list_rdata != id_reg)) begin
                    list_we     = 1'b1;
                    list_waddr  = walk_j_reg[ID_W-1:0];
                    list_wdata  = list_rdata;
                    walk_j_next = CNT_W'(walk_j_reg + 1'b1);
                end
                if (!walk_issue && !walk_rv_reg) begin
                    count_next = walk_j_reg;
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            head_wrap_reg <= 1'b0;
            tail_wrap_reg <= 1'b0;
            count_reg     <= '0;
            walk_rv_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            head_wrap_reg <= head_wrap_next;
            tail_wrap_reg <= tail_wrap_next;
            count_reg     <= count_next;
            walk_rv_reg   <= walk_rv_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        id_reg         <= id_next;
        comp_reg       <= comp_next;
        req_reg        <= req_next;
        res_status_reg <= res_status_next;
        res_ent_reg    <= res_ent_next;
        res_mask_reg   <= res_mask_next;
        res_all_reg    <= res_all_next;
        res_bit_reg    <= res_bit_next;
        walk_i_reg     <= walk_i_next;
        walk_j_reg     <= walk_j_next;
        if (out_load) begin
            m_status_reg     <= res_status_reg;
            m_entity_out_reg <= res_ent_reg;
            m_mask_out_reg   <= res_mask_reg;
            m_has_all_reg    <= res_all_reg;
            m_has_bit_reg    <= res_bit_reg;
            m_live_total_reg <= 11'(count_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_entity_out = m_entity_out_reg;
    assign m_mask_out   = m_mask_out_reg;
    assign m_has_all    = m_has_all_reg;
    assign m_has_bit    = m_has_bit_reg;
    assign m_live_total = m_live_total_reg;

    // The live count never exceeds the number of ids.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(ENTITY_COUNT))
        else $error("live count above entity count");

    // With no live ids the free list is full, so its pointers meet.
    a_empty_pointers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && count_reg == '0) |-> (head_reg == tail_reg))
        else $error("free-list pointers disagree with an empty live list");

    // The compaction write position never passes the read position.
    a_walk_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (walk_j_reg <= walk_i_reg))
        else $error("compaction overtook the list walk");

    // A finished walk dropped exactly one entry: the removed id.
    a_walk_drop_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && !walk_issue && !walk_rv_reg)
            |-> (({1'b0, walk_j_reg} + 1'b1) == {1'b0, count_reg}))
        else $error("removed id not found exactly once in the live list");

endmodule
